/* rtl/core/crc16_cobs_frame_encoder_defines.svh */
// Assertion macros shared by the encoder RTL.
// Each one takes a label, the clock, the reset and two expressions.
// Synthesis flows define SYNTHESIS and get empty bodies.
`ifndef CRC16_COBS_FRAME_ENCODER_DEFINES_SVH
`define CRC16_COBS_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// ante true implies cons true in the same cycle
`define CCFE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("encoder check failed");

// ante true implies cons true in the next cycle
`define CCFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("encoder check failed");

`else

`define CCFE_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CCFE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/ccfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ccfe_pkg;

   // COBS block limit and output packing
   localparam int MAX_BLOCK = 254;
   localparam int OUT_BYTES = 8;

   // derived widths
   localparam int FILL_W  = $clog2(MAX_BLOCK + 1);
   localparam int ADDR_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int PFILL_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
   localparam int PACK_W  = 8 * (OUT_BYTES - 1);

   // fixed field widths
   localparam int WORD_W  = 64;
   localparam int COUNT_W = 4;

   // CRC-16-CCITT, MSB first
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

endpackage

`default_nettype wire

/* rtl/core/crc16_cobs_frame_encoder.sv */
`timescale 1ns / 1ps
// Sequence: a payload byte is accepted, then takes 8 CRC bit steps on one shared
// shift/xor unit and one stuffing step; closing a block emits its code byte, then each
// byte read from the block buffer; a frame end then stuffs the two CRC bytes and emits
// code, block bytes and terminator, closing a block early at a zero or full-block CRC byte.
// Flow: ready only while the sequencer idles, so a new request waits until the last is done.
// Reset: synchronous, active high; clears CRC, fills and control, not the block buffer.
`default_nettype none

`include "crc16_cobs_frame_encoder_defines.svh"

module crc16_cobs_frame_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] has_byte
   input  wire logic        req_tlast,   // frame_end
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [63:0] out_word, [67:64] byte_count, [71:68] zero
   output logic             rsp_tlast    // frame_last
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CRC,
      S_STUFF,
      S_CODE,
      S_DATA,
      S_TERM
   } state_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_HI,
      PH_LO,
      PH_CLOSE
   } phase_type;

   state_type                      state_ff, state_in;
   phase_type                      phase_ff, phase_in;
   logic [15:0]                    crc_ff, crc_in;
   logic [7:0]                     cur_ff, cur_in;
   logic                           end_ff, end_in;
   logic [2:0]                     bit_ff, bit_in;
   logic [ccfe_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic [ccfe_pkg::FILL_W-1:0]    idx_ff, idx_in;
   logic [ccfe_pkg::PACK_W-1:0]    pack_ff, pack_in;
   logic [ccfe_pkg::PFILL_W-1:0]   pfill_ff, pfill_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ccfe_pkg::WORD_W-1:0]    rsp_word_ff, rsp_word_in;
   logic [ccfe_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                           rsp_last_ff, rsp_last_in;

   // block buffer
   logic [7:0]                     block_mem [ccfe_pkg::MAX_BLOCK];
   logic [7:0]                     rd_data_ff;
   logic [ccfe_pkg::ADDR_W-1:0]    rd_addr;
   logic                           mem_we;
   logic [ccfe_pkg::ADDR_W-1:0]    mem_waddr;

   logic                           accept;
   logic                           emit_ok;
   logic                           emit_go;
   logic [7:0]                     emit_byte;
   logic                           emit_last;
   logic                           adv;
   logic [ccfe_pkg::WORD_W-1:0]    word_merge;
   logic [ccfe_pkg::FILL_W-1:0]    fill_inc;
   logic [ccfe_pkg::FILL_W-1:0]    idx_inc;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit_ok    = !rsp_valid_ff || rsp_tready;
   assign fill_inc   = fill_ff + 1'b1;
   assign idx_inc    = idx_ff + 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

   // new byte lands above the bytes already packed
   assign word_merge = {{(ccfe_pkg::WORD_W - ccfe_pkg::PACK_W){1'b0}}, pack_ff}
                     | (ccfe_pkg::WORD_W'(emit_byte) << {pfill_ff, 3'b000});

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      crc_in       = crc_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      bit_in       = bit_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      emit_go      = 1'b0;
      emit_byte    = 8'h00;
      emit_last    = 1'b0;
      adv          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = fill_ff[ccfe_pkg::ADDR_W-1:0];
      rd_addr      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               end_in = req_tlast;
               if (req_tuser) begin
                  cur_in   = req_tdata;
                  crc_in   = crc_ff ^ {req_tdata, 8'h00};
                  bit_in   = '0;
                  state_in = S_CRC;
               end else if (req_tlast) begin
                  cur_in   = crc_ff[15:8];
                  phase_in = PH_HI;
                  state_in = S_STUFF;
               end
            end
         end
         S_CRC: begin
            // one bit of the CRC per cycle
            crc_in = crc_ff[15] ? ((crc_ff << 1) ^ ccfe_pkg::CRC_POLY) : (crc_ff << 1);
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 3'd7) begin
               phase_in = PH_DATA;
               state_in = S_STUFF;
            end
         end
         S_STUFF: begin
            if (cur_ff == 8'h00) begin
               state_in = S_CODE;
            end else begin
               mem_we  = 1'b1;
               fill_in = fill_inc;
               if (fill_inc == ccfe_pkg::FILL_W'(ccfe_pkg::MAX_BLOCK)) begin
                  state_in = S_CODE;
               end else begin
                  adv = 1'b1;
               end
            end
         end
         S_CODE: begin
            emit_go   = emit_ok;
            emit_byte = 8'(fill_ff) + 8'd1;
            if (emit_ok) begin
               if (fill_ff == '0) begin
                  adv = 1'b1;
               end else begin
                  idx_in   = '0;
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            emit_go   = emit_ok;
            emit_byte = rd_data_ff;
            rd_addr   = idx_ff[ccfe_pkg::ADDR_W-1:0];
            if (emit_ok) begin
               if (idx_inc == fill_ff) begin
                  fill_in = '0;
                  rd_addr = '0;
                  adv     = 1'b1;
               end else begin
                  idx_in  = idx_inc;
                  rd_addr = idx_inc[ccfe_pkg::ADDR_W-1:0];
               end
            end
         end
         S_TERM: begin
            emit_go   = emit_ok;
            emit_byte = 8'h00;
            emit_last = 1'b1;
            if (emit_ok) begin
               crc_in   = ccfe_pkg::CRC_INIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // next step of the frame once a byte or block is done
      if (adv) begin
         case (phase_ff)
            PH_DATA: begin
               if (end_ff) begin
                  cur_in   = crc_ff[15:8];
                  phase_in = PH_HI;
                  state_in = S_STUFF;
               end else begin
                  state_in = S_IDLE;
               end
            end
            PH_HI: begin
               cur_in   = crc_ff[7:0];
               phase_in = PH_LO;
               state_in = S_STUFF;
            end
            PH_LO: begin
               phase_in = PH_CLOSE;
               state_in = S_CODE;
            end
            PH_CLOSE: begin
               state_in = S_TERM;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   // output packing
   always_comb begin
      pack_in      = pack_ff;
      pfill_in     = pfill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_go) begin
         if (emit_last || (pfill_ff == ccfe_pkg::PFILL_W'(ccfe_pkg::OUT_BYTES - 1))) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = word_merge;
            rsp_count_in = ccfe_pkg::COUNT_W'(pfill_ff) + 1'b1;
            rsp_last_in  = emit_last;
            pack_in      = '0;
            pfill_in     = '0;
         end else begin
            pack_in  = word_merge[ccfe_pkg::PACK_W-1:0];
            pfill_in = pfill_ff + 1'b1;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_DATA;
         crc_ff       <= ccfe_pkg::CRC_INIT;
         end_ff       <= 1'b0;
         bit_ff       <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         pack_ff      <= '0;
         pfill_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         end_ff       <= end_in;
         bit_ff       <= bit_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         pack_ff      <= pack_in;
         pfill_ff     <= pfill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // block buffer, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         block_mem[mem_waddr] <= cur_ff;
      end
      rd_data_ff <= block_mem[rd_addr];
   end

   // checks
   `CCFE_ASSERT_IMPLY(a_fill_below_max, clock, reset, req_tready,
      fill_ff < ccfe_pkg::FILL_W'(ccfe_pkg::MAX_BLOCK))
   `CCFE_ASSERT_IMPLY(a_full_word, clock, reset, rsp_valid_ff && !rsp_last_ff,
      rsp_count_ff == ccfe_pkg::COUNT_W'(ccfe_pkg::OUT_BYTES))
   `CCFE_ASSERT_IMPLY(a_read_in_block, clock, reset, state_ff == S_DATA,
      idx_ff < fill_ff)
   `CCFE_ASSERT_NEXT(a_crc_restart, clock, reset, (state_ff == S_TERM) && emit_ok,
      (crc_ff == ccfe_pkg::CRC_INIT) && (fill_ff == '0) && rsp_last_ff)

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

   // one packed result word as the encoder should send it
   typedef struct packed {
      logic [ccfe_pkg::WORD_W-1:0]  word;
      logic [ccfe_pkg::COUNT_W-1:0] count;
      logic                         frame_last;
   } stuffed_word_type;

   // one request; typed rows carry their single result written out by hand
   typedef struct packed {
      logic [7:0]                   data;
      logic                         has_byte;
      logic                         frame_end;
      logic                         typed;
      logic [ccfe_pkg::WORD_W-1:0]  word;
      logic [ccfe_pkg::COUNT_W-1:0] count;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int requests_sent  = 0;
   int words_seen     = 0;
   int mismatch_count = 0;

   stuffed_word_type stuffed_words_due[$];

   // encoder state as predicted
   logic [15:0] crc_run  = ccfe_pkg::CRC_INIT;
   logic [7:0]  blk_bytes [ccfe_pkg::MAX_BLOCK];
   int          blk_fill = 0;
   logic [63:0] pk_word  = '0;
   int          pk_fill  = 0;

   // directed requests: extremes, empty frames, zero bytes, the standard check string
   stim_row_type directed_rows [22] = '{
      '{8'hA5, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0},                  // idle, data ignored
      '{8'h5A, 1'b0, 1'b1, 1'b1, 64'h0000_0000_00FF_FF03, 4'd4}, // empty frame after reset
      '{8'h00, 1'b1, 1'b1, 1'b1, 64'h0000_0000_F0E1_0301, 4'd5}, // lone zero byte
      '{8'h31, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h32, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h33, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h34, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h35, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h36, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h37, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h38, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h39, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 64'h0, 4'd0},                  // end without a byte
      '{8'hFF, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h7F, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h01, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},                  // zero mid frame
      '{8'h00, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0},                  // back-to-back zeros
      '{8'hFE, 1'b1, 1'b1, 1'b0, 64'h0, 4'd0},                  // byte on the end request
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0},                  // idle, data ignored
      '{8'h3C, 1'b0, 1'b1, 1'b1, 64'h0000_0000_00FF_FF03, 4'd4}  // empty frame again
   };

   crc16_cobs_frame_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("crc16_cobs_frame_encoder test failed");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // CRC-16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ ccfe_pkg::CRC_POLY) : (c << 1);
      return c;
   endfunction

   // pack one stuffed byte; a full word or the terminator makes a result
   task automatic pack_byte(input logic [7:0] b, input logic term);
      pk_word = pk_word | (64'(b) << (8 * pk_fill));
      pk_fill++;
      if (pk_fill >= ccfe_pkg::OUT_BYTES || term) begin
         stuffed_words_due.push_back(
            stuffed_word_type'{pk_word, ccfe_pkg::COUNT_W'(pk_fill), term});
         pk_word = '0;
         pk_fill = 0;
      end
   endtask

   task automatic close_block();
      pack_byte(8'(blk_fill + 1), 1'b0);
      for (int i = 0; i < blk_fill; i++)
         pack_byte(blk_bytes[i], 1'b0);
      blk_fill = 0;
   endtask

   task automatic stuff_byte(input logic [7:0] b);
      if (b == 8'h00) begin
         close_block();
      end else begin
         blk_bytes[blk_fill] = b;
         blk_fill++;
         if (blk_fill >= ccfe_pkg::MAX_BLOCK)
            close_block();
      end
   endtask

   // predicted stuffed words for one accepted request
   task automatic encode_request(input logic [7:0] d, input logic has, input logic fin);
      logic [15:0] crc_out;
      if (has) begin
         crc_run = crc_after(crc_run, d);
         stuff_byte(d);
      end
      if (fin) begin
         crc_out = crc_run;
         stuff_byte(crc_out[15:8]);
         stuff_byte(crc_out[7:0]);
         close_block();
         pack_byte(8'h00, 1'b1);
         crc_run = ccfe_pkg::CRC_INIT;
      end
   endtask

   function automatic stim_row_type make_row(input logic [7:0] d, input logic has,
                                             input logic fin);
      return stim_row_type'{d, has, fin, 1'b0, 64'h0, 4'd0};
   endfunction

   function automatic logic [7:0] pick_byte(input bit nonzero_only);
      if (!nonzero_only && $urandom_range(0, 4) == 0)
         return 8'h00;
      return 8'($urandom_range(1, 255));
   endfunction

   // drive one request and predict on acceptance
   task automatic send_req(input stim_row_type row);
      int depth;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.data;
      req_tuser  <= row.has_byte;
      req_tlast  <= row.frame_end;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      depth = stuffed_words_due.size();
      encode_request(row.data, row.has_byte, row.frame_end);
      if (row.typed) begin
         while (stuffed_words_due.size() > depth)
            void'(stuffed_words_due.pop_back());
         stuffed_words_due.push_back(stuffed_word_type'{row.word, row.count, 1'b1});
      end
      if (row.has_byte || row.frame_end)
         requests_sent++;
   endtask

   // one frame of len payload bytes, with idle noise between bytes
   task automatic send_frame(input int len, input bit nonzero_only);
      bit carry;
      int body;
      carry = (len > 0) && ($urandom_range(0, 1) == 1);
      body  = carry ? len - 1 : len;
      for (int i = 0; i < body; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_req(make_row(8'($urandom_range(0, 255)), 1'b0, 1'b0));
         send_req(make_row(pick_byte(nonzero_only), 1'b1, 1'b0));
      end
      if (carry)
         send_req(make_row(pick_byte(nonzero_only), 1'b1, 1'b1));
      else
         send_req(make_row(8'($urandom_range(0, 255)), 1'b0, 1'b1));
   endtask

   // hold the sender until every predicted word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stuffed_words_due.size() != 0)
         @(posedge clock);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // compare each returned word with the oldest prediction
   always @(posedge clock) begin : check_words
      stuffed_word_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (stuffed_words_due.size() == 0) begin
            flag_mismatch($sformatf("word %0d unexpected: %h", words_seen, rsp_tdata));
         end else begin
            due = stuffed_words_due.pop_front();
            if (rsp_tdata[63:0] !== due.word)
               flag_mismatch($sformatf("word %0d out_word %h, want %h",
                                       words_seen, rsp_tdata[63:0], due.word));
            if (rsp_tdata[67:64] !== due.count)
               flag_mismatch($sformatf("word %0d byte_count %0d, want %0d",
                                       words_seen, rsp_tdata[67:64], due.count));
            if (rsp_tdata[71:68] !== 4'h0)
               flag_mismatch($sformatf("word %0d pad bits %h", words_seen, rsp_tdata[71:68]));
            if (rsp_tlast !== due.frame_last)
               flag_mismatch($sformatf("word %0d frame_last %b, want %b",
                                       words_seen, rsp_tlast, due.frame_last));
         end
      end
   end

   initial begin : stimulus
      int target;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < 4; ph++) begin
         // idling profile per phase
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 67; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 67; end
            default: begin send_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         drain();
         if (ph == 0) begin
            foreach (directed_rows[r])
               send_req(directed_rows[r]);
         end
         target = requests_sent + 30;
         while (requests_sent < target)
            send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(0, 12), 1'b0);
      end

      drain();
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && stuffed_words_due.size() == 0)
         $display("crc16_cobs_frame_encoder test passed");
      else
         $display("crc16_cobs_frame_encoder test failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ccfe_pkg.sv
rtl/core/crc16_cobs_frame_encoder.sv
test/tb.sv
